/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB package
// Payload types, sector codes and fixed-point constants for the HSV to RGB
// pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // Hue in 1/128 degree; one 60 degree sector spans 7680 units.
  localparam int unsigned REM_W = 13;

  localparam logic [15:0] SECTOR_UNITS = 16'd7680;
  localparam logic [15:0] HUE_LIMIT    = 16'd46080;
  localparam logic [7:0]  FULL_SCALE   = 8'd255;

  // Fraction denominator: 7680 * 255.
  localparam logic [20:0] FRAC_DEN = 21'd1958400;

  // FRAC_DEN is 2^9 * 3825, so the quotient is taken after a 9-bit shift.
  localparam int unsigned DEN_SHIFT = 9;

  // Reciprocals: floor(x / 255) = (x * RECIP_255) >> 24 for x below 2^16,
  // floor(z / 3825) = (z * RECIP_3825) >> 32 for z below 2^20.
  localparam logic [16:0] RECIP_255  = 17'd65794;
  localparam logic [20:0] RECIP_3825 = 21'd1122868;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hue_in_range;
  } rgb_t;

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a hue, saturation and value triple into an 8-bit RGB pixel with
// the six-sector scheme in exact fixed point, one request per clock.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ---------------------------------
//   hsv       hsv_valid / hsv_ready      hue, saturation, brightness
//   rgb       rgb_valid / rgb_ready      red, green, blue, hue_in_range
//
// A request passes five register stages, s1 to s4 and then the output register,
// and a new request is accepted every cycle while the pipeline is not held.
// The depth is set by the chained multiplications for each channel (fraction
// product, level product, then a reciprocal multiply for the constant
// division), one per stage, each followed by a register.
// The whole pipeline holds while a result waits and rgb_ready is low.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hsv_valid,
  output logic                    hsv_ready,
  input  wire hsv2rgb_pkg::hsv_t  hsv,
  output logic                    rgb_valid,
  input  wire logic               rgb_ready,
  output hsv2rgb_pkg::rgb_t       rgb
);

  import hsv2rgb_pkg::*;

  logic       advance;
  logic [4:0] stage_valid;

  // Stage 1: sector decode.
  sector_t          sector_c;
  logic [15:0]      base_c;
  sector_t          s1_sector;
  logic [REM_W-1:0] s1_rem;
  logic [7:0]       s1_sat;
  logic [7:0]       s1_val;
  logic             s1_ok;

  // Stage 2: first products.
  logic [REM_W-1:0] rem_inv_c;
  logic [20:0]      rs_c;
  logic [20:0]      ts_c;
  sector_t          s2_sector;
  logic [7:0]       s2_val;
  logic             s2_ok;
  logic [15:0]      s2_pnum;
  logic [20:0]      s2_nq;
  logic [20:0]      s2_nt;

  // Stage 3: level products.
  sector_t          s3_sector;
  logic [7:0]       s3_val;
  logic             s3_ok;
  logic [32:0]      s3_yp;
  logic [28:0]      s3_yq;
  logic [28:0]      s3_yt;

  // Stage 4: reciprocal multiplies.
  logic [40:0]      zq_c;
  logic [40:0]      zt_c;
  sector_t          s4_sector;
  logic [7:0]       s4_val;
  logic             s4_ok;
  logic [7:0]       s4_p;
  logic [7:0]       s4_q;
  logic [7:0]       s4_t;

  // Stage 5: routing into the output register.
  rgb_t             rgb_next;

  assign advance   = !stage_valid[4] || rgb_ready;
  assign hsv_ready = advance;
  assign rgb_valid = stage_valid[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[3:0], hsv_valid};
    end
  end

  always_comb begin
    if (hsv.hue >= SECTOR_UNITS * 16'd5) begin
      sector_c = SECTOR_5;
      base_c   = SECTOR_UNITS * 16'd5;
    end else if (hsv.hue >= SECTOR_UNITS * 16'd4) begin
      sector_c = SECTOR_4;
      base_c   = SECTOR_UNITS * 16'd4;
    end else if (hsv.hue >= SECTOR_UNITS * 16'd3) begin
      sector_c = SECTOR_3;
      base_c   = SECTOR_UNITS * 16'd3;
    end else if (hsv.hue >= SECTOR_UNITS * 16'd2) begin
      sector_c = SECTOR_2;
      base_c   = SECTOR_UNITS * 16'd2;
    end else if (hsv.hue >= SECTOR_UNITS) begin
      sector_c = SECTOR_1;
      base_c   = SECTOR_UNITS;
    end else begin
      sector_c = SECTOR_0;
      base_c   = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sector <= sector_c;
      s1_rem    <= REM_W'(hsv.hue - base_c);
      s1_sat    <= hsv.saturation;
      s1_val    <= hsv.brightness;
      s1_ok     <= hsv.hue < HUE_LIMIT;
    end
  end

  assign rem_inv_c = REM_W'(SECTOR_UNITS) - s1_rem;
  assign rs_c      = 21'(s1_rem) * 21'(s1_sat);
  assign ts_c      = 21'(rem_inv_c) * 21'(s1_sat);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sector <= s1_sector;
      s2_val    <= s1_val;
      s2_ok     <= s1_ok;
      s2_pnum   <= 16'(s1_val) * 16'(FULL_SCALE - s1_sat);
      s2_nq     <= FRAC_DEN - rs_c;
      s2_nt     <= FRAC_DEN - ts_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sector <= s2_sector;
      s3_val    <= s2_val;
      s3_ok     <= s2_ok;
      s3_yp     <= 33'(s2_pnum) * 33'(RECIP_255);
      s3_yq     <= 29'(s2_val) * 29'(s2_nq);
      s3_yt     <= 29'(s2_val) * 29'(s2_nt);
    end
  end

  assign zq_c = 41'(s3_yq[28:DEN_SHIFT]) * 41'(RECIP_3825);
  assign zt_c = 41'(s3_yt[28:DEN_SHIFT]) * 41'(RECIP_3825);

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
      s4_ok     <= s3_ok;
      s4_p      <= s3_yp[31:24];
      s4_q      <= zq_c[39:32];
      s4_t      <= zt_c[39:32];
    end
  end

  always_comb begin
    rgb_next.hue_in_range = s4_ok;
    case (s4_sector)
      SECTOR_0: begin
        rgb_next.red   = s4_val;
        rgb_next.green = s4_t;
        rgb_next.blue  = s4_p;
      end
      SECTOR_1: begin
        rgb_next.red   = s4_q;
        rgb_next.green = s4_val;
        rgb_next.blue  = s4_p;
      end
      SECTOR_2: begin
        rgb_next.red   = s4_p;
        rgb_next.green = s4_val;
        rgb_next.blue  = s4_t;
      end
      SECTOR_3: begin
        rgb_next.red   = s4_p;
        rgb_next.green = s4_q;
        rgb_next.blue  = s4_val;
      end
      SECTOR_4: begin
        rgb_next.red   = s4_t;
        rgb_next.green = s4_p;
        rgb_next.blue  = s4_val;
      end
      default: begin
        rgb_next.red   = s4_val;
        rgb_next.green = s4_p;
        rgb_next.blue  = s4_q;
      end
    endcase
    if (!s4_ok) begin
      rgb_next.red   = 8'd0;
      rgb_next.green = 8'd0;
      rgb_next.blue  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire
